FILE: hw/rtl/tween_easing_progress_macros.svh
// assertion macros for the tween easing progress block
// used by the checker; needs a clk and rst in the scope of each use
`ifndef TWEEN_EASING_PROGRESS_MACROS_SVH
`define TWEEN_EASING_PROGRESS_MACROS_SVH

// same-cycle implication, held off while in reset
`define TEP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, held off while in reset
`define TEP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: hw/rtl/tep_pkg.sv
// shared types and constants for the tween easing progress block
// no dependencies; imported by the top level, the checker and the testbench
package tep_pkg;

  localparam int DUR_W   = 32;
  localparam int FRAME_W = 16;
  localparam int FRAC_W  = 16;
  localparam int Q_W     = 17;
  localparam int SQ_W    = 34;
  localparam int PROD_W  = 51;
  localparam int CNT_W   = 4;
  localparam int IDX_W   = 2;
  localparam int SH_W    = 6;

  localparam logic [Q_W-1:0]   ONE_Q16  = 17'h10000;
  localparam logic [Q_W-1:0]   HALF_Q16 = 17'h08000;
  localparam logic [CNT_W-1:0] DIV_LAST = 4'd15;

  localparam logic [IDX_W-1:0] REG_DURATION  = 2'd0;
  localparam logic [IDX_W-1:0] REG_STYLE     = 2'd1;
  localparam logic [IDX_W-1:0] REG_DIRECTION = 2'd2;

  localparam logic [1:0] STYLE_QUAD  = 2'd1;
  localparam logic [1:0] STYLE_CUBIC = 2'd2;
  localparam logic [1:0] DIR_OUT     = 2'd1;
  localparam logic [1:0] DIR_INOUT   = 2'd2;

  localparam logic ACT_START = 1'b1;

  localparam logic [SH_W-1:0] SH_QUAD     = 6'd16;
  localparam logic [SH_W-1:0] SH_QUAD_IO  = 6'd15;
  localparam logic [SH_W-1:0] SH_CUBIC    = 6'd32;
  localparam logic [SH_W-1:0] SH_CUBIC_IO = 6'd30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ,
    ST_CUBE,
    ST_FIN
  } state_t;

endpackage

FILE: hw/rtl/tween_easing_progress.sv
// tween easing progress: one tween channel, elapsed time, progress divide, easing curve
// depends on tep_pkg
// a tick that finishes the tween skips the bit-serial progress divide (ST_DIV)
// curves then use the shared multiply (ST_SQ, ST_CUBE if cubic), then the load (ST_FIN)
// no new tick is taken until the last result loads; start and idle ticks one per cycle
// reset: rst is synchronous; clears registers, disarms, drops out_valid
module tween_easing_progress (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [tep_pkg::FRAME_W-1:0]   frame_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tep_pkg::Q_W-1:0]       eased_value,
  output logic                          done_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tep_pkg::IDX_W-1:0]     cfg_index,
  input  logic [tep_pkg::DUR_W-1:0]     cfg_data
);
  import tep_pkg::*;

  state_t state, state_next;

  logic [DUR_W-1:0]  duration;
  logic [1:0]        curve_kind;
  logic [1:0]        curve_dir;
  logic              armed;
  logic [DUR_W-1:0]  elapsed_time;

  logic [DUR_W-1:0]  rem;
  logic [CNT_W-1:0]  div_cnt;
  logic [Q_W-1:0]    p;
  logic [PROD_W-1:0] prod;
  logic              done_hold;

  logic [DUR_W:0]    sum_ext;
  logic [DUR_W-1:0]  sum_sat;
  logic              reach;
  logic              in_take;
  logic              tick_go;
  logic              curve;
  logic              cubic;
  logic              inout_dir;
  logic              invert;
  logic [Q_W-1:0]    q;
  logic [Q_W-1:0]    x;
  logic [DUR_W:0]    rem_shift;
  logic [DUR_W:0]    rem_diff;
  logic              fits;
  logic [SQ_W-1:0]   mul_a;
  logic [PROD_W-1:0] mul_out;
  logic [SH_W-1:0]   sh;
  logic [PROD_W-1:0] term_wide;
  logic [Q_W-1:0]    term;
  logic [Q_W-1:0]    value;
  logic              out_load;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && in_ready;

  // elapsed time plus frame time, saturating
  assign sum_ext = {1'b0, elapsed_time} + {{(DUR_W + 1 - FRAME_W){1'b0}}, frame_time};
  assign sum_sat = sum_ext[DUR_W] ? {DUR_W{1'b1}} : sum_ext[DUR_W-1:0];
  assign reach   = (sum_sat >= duration);
  assign tick_go = in_take && (action != ACT_START) && armed;

  assign cubic     = (curve_kind == STYLE_CUBIC);
  assign curve     = (curve_kind == STYLE_QUAD) || cubic;
  assign inout_dir = (curve_dir == DIR_INOUT);
  assign invert    = (curve_dir == DIR_OUT) || (inout_dir && (p >= HALF_Q16));
  assign q         = ONE_Q16 - p;
  assign x         = invert ? q : p;

  // one restoring divide step per cycle
  assign rem_shift = {rem, 1'b0};
  assign fits      = (rem_shift >= {1'b0, duration});
  assign rem_diff  = rem_shift - {1'b0, duration};

  // shared multiplier: x*x, then (x*x)*x for cubic
  assign mul_a   = (state == ST_CUBE) ? prod[SQ_W-1:0] : {{(SQ_W - Q_W){1'b0}}, x};
  assign mul_out = {{(PROD_W - SQ_W){1'b0}}, mul_a} * {{(PROD_W - Q_W){1'b0}}, x};

  always_comb begin
    case ({cubic, inout_dir})
      2'b00:   sh = SH_QUAD;
      2'b01:   sh = SH_QUAD_IO;
      2'b10:   sh = SH_CUBIC;
      2'b11:   sh = SH_CUBIC_IO;
      default: sh = SH_QUAD;
    endcase
  end

  assign term_wide = prod >> sh;
  assign term      = term_wide[Q_W-1:0];
  assign value     = !curve ? p : (invert ? (ONE_Q16 - term) : term);

  assign out_load = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (tick_go) begin
          if (reach) state_next = curve ? ST_SQ : ST_FIN;
          else       state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt == DIV_LAST) state_next = curve ? ST_SQ : ST_FIN;
      end
      ST_SQ:   state_next = cubic ? ST_CUBE : ST_FIN;
      ST_CUBE: state_next = ST_FIN;
      ST_FIN: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duration   <= '0;
      curve_kind <= '0;
      curve_dir  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DURATION:  duration   <= cfg_data;
        REG_STYLE:     curve_kind <= cfg_data[1:0];
        REG_DIRECTION: curve_dir  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      elapsed_time <= '0;
    end else if (in_take) begin
      if (action == ACT_START) begin
        armed        <= 1'b1;
        elapsed_time <= '0;
      end else if (armed) begin
        if (reach) begin
          armed        <= 1'b0;
          elapsed_time <= '0;
        end else begin
          elapsed_time <= sum_sat;
        end
      end
    end
  end

  // quotient bits shift into p, msb first
  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      div_cnt   <= '0;
      p         <= '0;
      prod      <= '0;
      done_hold <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (tick_go) begin
            rem       <= sum_sat;
            div_cnt   <= '0;
            p         <= reach ? ONE_Q16 : '0;
            done_hold <= reach;
          end
        end
        ST_DIV: begin
          rem     <= fits ? rem_diff[DUR_W-1:0] : rem_shift[DUR_W-1:0];
          p       <= {p[FRAC_W-1:0], fits};
          div_cnt <= div_cnt + CNT_W'(1);
        end
        ST_SQ, ST_CUBE: prod <= mul_out;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      eased_value <= '0;
      done_res    <= 1'b0;
    end else if (out_load) begin
      out_valid   <= 1'b1;
      eased_value <= value;
      done_res    <= done_hold;
    end else if (out_ready) begin
      out_valid   <= 1'b0;
    end
  end
endmodule

FILE: hw/rtl/tep_checker.sv
// port-level checker for the tween easing progress block, bound to the top level
// depends on tep_pkg and tween_easing_progress_macros.svh
`include "tween_easing_progress_macros.svh"

module tep_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    action,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [tep_pkg::Q_W-1:0] eased_value,
  input logic                    done_res
);
  import tep_pkg::*;

  logic start_xfer;
  assign start_xfer = in_valid && in_ready && (action == ACT_START);

  // eased progress never exceeds one
  `TEP_ASSERT_NOW(a_value_range, out_valid, eased_value <= ONE_Q16)
  // a finishing tick always lands on full progress
  `TEP_ASSERT_NOW(a_done_full, out_valid && done_res, eased_value == ONE_Q16)
  // a start transfer on an empty output never produces a result
  `TEP_ASSERT_NEXT(a_start_silent, start_xfer && !out_valid, !out_valid)
  // a stalled result holds
  `TEP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(eased_value) && $stable(done_res))

endmodule

bind tween_easing_progress tep_checker u_tep_checker (.*);

FILE: tb/sv/tween_easing_progress_tb.sv
// self-checking testbench for the tween easing progress block
// holds a scoreboard class that predicts each eased result, plus the drive tasks
// depends on tep_pkg and tween_easing_progress
`timescale 1ns / 100ps

module tween_easing_progress_tb;
  import tep_pkg::*;

  localparam logic             ACT_TICK      = 1'b0;
  localparam logic [1:0]       STYLE_LINEAR  = 2'd0;
  localparam logic [1:0]       STYLE_RSVD    = 2'd3;
  localparam logic [1:0]       DIR_IN        = 2'd0;
  localparam logic [1:0]       DIR_RSVD      = 2'd3;
  localparam logic [IDX_W-1:0] REG_UNUSED    = 2'd3;
  localparam int               RANDOM_ITEMS  = 1350;
  localparam int               SETTLE_CYCLES = 24;
  localparam int               CYCLE_LIMIT   = 6000000;

  typedef struct packed {
    logic [Q_W-1:0] value;
    logic           done;
  } tween_result_t;

  class tween_scoreboard;
    logic [DUR_W-1:0] duration  = '0;
    logic [1:0]       style     = '0;
    logic [1:0]       direction = '0;
    bit               armed     = 1'b0;
    logic [DUR_W-1:0] elapsed   = '0;
    tween_result_t    pending_results[$];
    int               errors    = 0;

    function void set_reg(logic [IDX_W-1:0] idx, logic [DUR_W-1:0] data);
      case (idx)
        REG_DURATION:  duration = data;
        REG_STYLE:     style = data[1:0];
        REG_DIRECTION: direction = data[1:0];
        default: ;
      endcase
    endfunction

    function logic [Q_W-1:0] progress();
      logic [63:0] quo;
      if (duration == '0 || elapsed >= duration) return ONE_Q16;
      quo = {16'b0, elapsed, 16'b0} / {32'b0, duration};
      return quo[Q_W-1:0];
    endfunction

    // x^2 >> 16 or x^3 >> 32, times scale, truncated once
    function logic [Q_W-1:0] curve_term(logic [Q_W-1:0] x, bit cube, logic [2:0] scale);
      logic [63:0] sq;
      logic [63:0] full;
      sq = 64'(x) * 64'(x);
      if (cube) full = (sq * 64'(x) * 64'(scale)) >> 32;
      else full = (sq * 64'(scale)) >> 16;
      return full[Q_W-1:0];
    endfunction

    function logic [Q_W-1:0] eased(logic [Q_W-1:0] p);
      logic [Q_W-1:0] q;
      bit             cube;
      logic [2:0]     io_scale;
      q = ONE_Q16 - p;
      if (style == STYLE_QUAD) begin
        cube = 1'b0;
        io_scale = 3'd2;
      end else if (style == STYLE_CUBIC) begin
        cube = 1'b1;
        io_scale = 3'd4;
      end else begin
        return p;
      end
      if (direction == DIR_OUT) return ONE_Q16 - curve_term(q, cube, 3'd1);
      if (direction == DIR_INOUT) begin
        if (p < HALF_Q16) return curve_term(p, cube, io_scale);
        return ONE_Q16 - curve_term(q, cube, io_scale);
      end
      return curve_term(p, cube, 3'd1);
    endfunction

    function void accept_item(logic act, logic [FRAME_W-1:0] ft);
      logic [DUR_W:0] sum;
      tween_result_t  r;
      if (act == ACT_START) begin
        armed = 1'b1;
        elapsed = '0;
        return;
      end
      if (!armed) return;
      sum = {1'b0, elapsed} + {17'b0, ft};
      elapsed = sum[DUR_W] ? '1 : sum[DUR_W-1:0];
      r.value = eased(progress());
      r.done = (elapsed >= duration);
      pending_results.push_back(r);
      if (r.done) begin
        armed = 1'b0;
        elapsed = '0;
      end
    endfunction

    function void check_result(logic [Q_W-1:0] value, logic done);
      tween_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result transfer: eased_value %0d done_res %0d", value, done);
        return;
      end
      e = pending_results.pop_front();
      if (value !== e.value || done !== e.done) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: eased_value exp %0d got %0d, done_res exp %0d got %0d",
                   e.value, value, e.done, done);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic               action     = 1'b0;
  logic [FRAME_W-1:0] frame_time = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [Q_W-1:0]     eased_value;
  logic               done_res;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index  = '0;
  logic [DUR_W-1:0]   cfg_data   = '0;

  tween_scoreboard sb = new;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int cycle_count  = 0;

  tween_easing_progress u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .frame_time  (frame_time),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .eased_value (eased_value),
    .done_res    (done_res),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  // valid stays high after a transfer unless the next item starts with a gap
  task automatic send_item(input logic act, input logic [FRAME_W-1:0] ft);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    frame_time <= ft;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.accept_item(act, ft);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // start and idle ticks give no result, so allow for a late divide after the queue empties
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [DUR_W-1:0] dur, input logic [1:0] sty,
                           input logic [1:0] dir);
    logic [DUR_W-1:0] junk;
    junk = $urandom();
    settle();
    write_reg(REG_DURATION, dur);
    // upper data bits are don't-care for the 2-bit registers
    write_reg(REG_STYLE, {junk[DUR_W-1:2], sty});
    junk = $urandom();
    write_reg(REG_DIRECTION, {junk[DUR_W-1:2], dir});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom_range(16, 1);
      2, 3:    return $urandom_range(2000, 17);
      4, 5:    return $urandom_range(200000, 2001);
      6:       return $urandom_range(3000000, 200001);
      7:       return $urandom_range(1) ? 32'd65535 : 32'd65536;
      8:       return $urandom();
      default: return 32'hFFFF_FFFF - $urandom_range(1);
    endcase
  endfunction

  // half the time, steps of dur/24 to dur/3, capped to fit frame_time
  function automatic logic [FRAME_W-1:0] pick_frame(input logic [DUR_W-1:0] dur);
    logic [DUR_W-1:0] step;
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return FRAME_W'($urandom());
      default: begin
        step = dur / $urandom_range(12, 3);
        if (step > 32'd65535) step = 32'd65535;
        return FRAME_W'($urandom_range(step, step / 2));
      end
    endcase
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(eased_value, done_res);
      out_ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tween_easing_progress_tb: FAIL");
    $finish;
  end

  initial begin
    int  counted;
    int  n;
    logic act;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    set_idling(24, 82);
    write_reg(REG_UNUSED, $urandom());
    cfg_valid <= 1'b0;

    // zero duration: the first tick after start finishes; ticks while idle are dropped
    configure(32'd0, STYLE_LINEAR, DIR_IN);
    send_item(ACT_TICK, 16'hFFFF);
    send_item(ACT_START, 16'h0000);
    send_item(ACT_TICK, 16'h0000);
    send_item(ACT_TICK, 16'h5A5A);

    // longest duration, restart while armed
    configure(32'hFFFF_FFFF, STYLE_CUBIC, DIR_INOUT);
    send_item(ACT_START, 16'hFFFF);
    send_item(ACT_TICK, 16'h0000);
    send_item(ACT_TICK, 16'hFFFF);
    send_item(ACT_START, 16'h1234);
    send_item(ACT_TICK, 16'hFFFF);

    // progress lands exactly on the in-out half point
    configure(32'd2, STYLE_QUAD, DIR_INOUT);
    send_item(ACT_START, 16'h0000);
    send_item(ACT_TICK, 16'h0001);
    send_item(ACT_TICK, 16'h0001);

    // reserved style and direction codes
    configure(32'd65536, STYLE_RSVD, DIR_RSVD);
    send_item(ACT_START, 16'h0000);
    send_item(ACT_TICK, 16'hFFFF);
    send_item(ACT_TICK, 16'hFFFF);

    configure(32'd3, STYLE_CUBIC, DIR_OUT);
    send_item(ACT_START, 16'h0000);
    send_item(ACT_TICK, 16'h0001);
    send_item(ACT_TICK, 16'h0001);
    send_item(ACT_TICK, 16'h0001);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted < RANDOM_ITEMS / 3) set_idling(24, 82);
      else if (counted < 2 * RANDOM_ITEMS / 3) set_idling(82, 24);
      else set_idling(0, 0);
      configure(pick_duration(), 2'($urandom_range(3)), 2'($urandom_range(3)));
      n = $urandom_range(45, 20);
      repeat (n) begin
        if (sb.armed) act = ($urandom_range(99) < 5) ? ACT_START : ACT_TICK;
        else act = ($urandom_range(99) < 85) ? ACT_START : ACT_TICK;
        if (act == ACT_START || sb.armed) counted++;
        send_item(act, pick_frame(sb.duration));
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tween_easing_progress_tb: PASS");
    end else begin
      $display("tween_easing_progress_tb: FAIL");
    end
    $finish;
  end

endmodule
